// ===== rtl/core/keyframe_track_lerp_sampler_core_assert.svh =====
// Assertion macros used by the keyframe sampler back end (kts_back).
`ifndef KEYFRAME_TRACK_LERP_SAMPLER_CORE_ASSERT_SVH
`define KEYFRAME_TRACK_LERP_SAMPLER_CORE_ASSERT_SVH
// same-cycle implication, checked on clk, disabled in reset
`define KTS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define KTS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== rtl/core/kts_pkg.sv =====
// Types and constants of the keyframe track sampler.
`timescale 1ns / 1ps
`default_nettype none
package kts_pkg;
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic CFG_KEY_COUNT   = 1'b0;
	localparam logic CFG_EMPTY_VALUE = 1'b1;

	localparam logic [1:0] ST_WRITE = 2'd0;
	localparam logic [1:0] ST_LERP  = 2'd1;
	localparam logic [1:0] ST_HOLD  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	typedef struct packed {
		logic        is_write;
		logic        slot_ok;
		logic [5:0]  slot;
		logic [31:0] key_time;
		logic [31:0] key_x;
		logic [31:0] key_y;
		logic [31:0] key_z;
		logic [31:0] sample_time;
	} cmd_t;

	typedef struct packed {
		logic [6:0]  key_count;
		logic [31:0] empty_value;
	} cfg_t;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [1:0]  status;
		logic        saturated;
	} rsp_t;
endpackage
`default_nettype wire

// ===== rtl/core/kts_if.sv =====
// Channel interfaces: request, response and configuration write.
`timescale 1ns / 1ps
`default_nettype none
interface kts_req_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [5:0]  key_index;
	logic [31:0] key_time;
	logic signed [31:0] key_x;
	logic signed [31:0] key_y;
	logic signed [31:0] key_z;
	logic [31:0] sample_time;
	modport source (output valid, op, key_index, key_time, key_x, key_y, key_z, sample_time,
		input ready);
	modport sink (input valid, op, key_index, key_time, key_x, key_y, key_z, sample_time,
		output ready);
endinterface

interface kts_rsp_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic [1:0]  status;
	logic        saturated;
	modport source (output valid, out_x, out_y, out_z, status, saturated, input ready);
	modport sink (input valid, out_x, out_y, out_z, status, saturated, output ready);
endinterface

interface kts_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/kts_front.sv =====
// Front end: accepts request beats, classifies them, registers one command.
`timescale 1ns / 1ps
`default_nettype none
module kts_front #(
	parameter int MAX_KEYS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	kts_req_if.sink          req,
	output logic             push_valid,
	input  wire logic        push_ready,
	output kts_pkg::cmd_t    push_cmd
);
	logic          valid_s1;
	kts_pkg::cmd_t cmd_s1;
	kts_pkg::cmd_t cmd_c;
	logic          take;

	assign req.ready = !valid_s1 || push_ready;
	assign take      = req.valid && req.ready;

	always_comb begin
		cmd_c.is_write    = (req.op == kts_pkg::OP_WRITE);
		cmd_c.slot_ok     = (32'(req.key_index) < MAX_KEYS);
		cmd_c.slot        = req.key_index;
		cmd_c.key_time    = req.key_time;
		cmd_c.key_x       = req.key_x;
		cmd_c.key_y       = req.key_y;
		cmd_c.key_z       = req.key_z;
		cmd_c.sample_time = req.sample_time;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd_c;
		end
	end

	assign push_valid = valid_s1;
	assign push_cmd   = cmd_s1;
endmodule
`default_nettype wire

// ===== rtl/core/kts_queue.sv =====
// Two-entry command queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module kts_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	output logic               push_ready,
	input  wire kts_pkg::cmd_t push_cmd,
	output logic               pop_valid,
	input  wire logic          pop,
	output kts_pkg::cmd_t      pop_cmd
);
	kts_pkg::cmd_t ent_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;
	logic          do_push;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign do_push    = push_valid && push_ready;
	assign pop_cmd    = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= push_cmd;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/kts_back.sv =====
// Back end: key store, binary search, serial divide, lerp, result register.
`timescale 1ns / 1ps
`default_nettype none
`include "keyframe_track_lerp_sampler_core_assert.svh"
module kts_back #(
	parameter int MAX_KEYS = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire kts_pkg::cfg_t cfg,
	input  wire logic          q_valid,
	output logic               q_pop,
	input  wire kts_pkg::cmd_t q_cmd,
	output logic               out_valid,
	input  wire logic          out_ready,
	output kts_pkg::rsp_t      out_rsp
);
	localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int CW = $clog2(MAX_KEYS + 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SRCH = 4'd1;
	localparam logic [3:0] S_CMP  = 4'd2;
	localparam logic [3:0] S_HOLD = 4'd3;
	localparam logic [3:0] S_LD1  = 4'd4;
	localparam logic [3:0] S_LD2  = 4'd5;
	localparam logic [3:0] S_DIV  = 4'd6;
	localparam logic [3:0] S_FRAC = 4'd7;
	localparam logic [3:0] S_MUL  = 4'd8;
	localparam logic [3:0] S_ADD  = 4'd9;

	localparam logic [5:0] DIV_LAST = 6'd47;
	localparam logic signed [49:0] R_MAX = 50'sh0_7FFF_FFFF;
	localparam logic signed [49:0] R_MIN = -50'sh0_8000_0000;

	logic [31:0] time_mem [MAX_KEYS];
	logic [31:0] x_mem    [MAX_KEYS];
	logic [31:0] y_mem    [MAX_KEYS];
	logic [31:0] z_mem    [MAX_KEYS];
	logic [31:0] rd_time, rd_x, rd_y, rd_z;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic          wr_en;

	logic [3:0]    state_q;
	logic [31:0]   qt_q;
	logic [CW-1:0] n_q, first_q, count_q, mid_q, idx_q;
	logic [CW-1:0] n_now, mid_c, idx_c;
	logic          hold_c;
	logic [31:0]   t1_q;
	logic [31:0]   v1_q [3];
	logic [31:0]   v2_q [3];
	logic [31:0]   dt_q, rem_q;
	logic [47:0]   quo_q;
	logic          neg_q;
	logic [5:0]    cnt_q;
	logic [32:0]   rem_sh, trial;
	logic signed [31:0] frac_q;
	logic          sat_q;
	logic [1:0]    comp_q;
	logic signed [32:0] diff_c;
	logic signed [64:0] prod_c, prod_q, sh_c;
	logic signed [49:0] sum_c;
	logic          rsat_c;
	logic [31:0]   rval_c;
	logic [31:0]   res_q [3];
	logic [31:0]   mag_c;

	logic          res_fire;
	kts_pkg::rsp_t res_rsp;
	logic          out_valid_q;
	kts_pkg::rsp_t out_rsp_q;

	assign n_now = (cfg.key_count > MAX_KEYS) ? CW'(MAX_KEYS) : CW'(cfg.key_count);
	assign q_pop = (state_q == S_IDLE) && q_valid && (!out_valid_q || out_ready);
	assign wr_en = q_pop && q_cmd.is_write && q_cmd.slot_ok;
	assign wr_addr = AW'(q_cmd.slot);

	assign mid_c  = first_q + (count_q >> 1);
	assign idx_c  = (first_q == '0) ? '0 : first_q - CW'(1);
	assign hold_c = (idx_c >= n_q - CW'(1));

	assign rem_sh = {rem_q, quo_q[47]};
	assign trial  = rem_sh - {1'b0, dt_q};

	assign diff_c = $signed({v2_q[comp_q][31], v2_q[comp_q]})
		- $signed({v1_q[comp_q][31], v1_q[comp_q]});
	assign prod_c = diff_c * frac_q;
	assign sh_c   = prod_q >>> 16;
	assign sum_c  = $signed({{18{v1_q[comp_q][31]}}, v1_q[comp_q]}) + sh_c[49:0];
	assign rsat_c = (sum_c > R_MAX) || (sum_c < R_MIN);
	assign rval_c = (sum_c > R_MAX) ? 32'h7FFF_FFFF :
		(sum_c < R_MIN) ? 32'h8000_0000 : sum_c[31:0];
	assign mag_c  = (qt_q < t1_q) ? t1_q - qt_q : qt_q - t1_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			time_mem[wr_addr] <= q_cmd.key_time;
			x_mem[wr_addr]    <= q_cmd.key_x;
			y_mem[wr_addr]    <= q_cmd.key_y;
			z_mem[wr_addr]    <= q_cmd.key_z;
		end
		rd_time <= time_mem[rd_addr];
		rd_x    <= x_mem[rd_addr];
		rd_y    <= y_mem[rd_addr];
		rd_z    <= z_mem[rd_addr];
	end

	always_comb begin
		rd_addr  = AW'(mid_c);
		res_fire = 1'b0;
		res_rsp  = '0;
		unique case (state_q)
			S_IDLE: begin
				if (q_pop && q_cmd.is_write) begin
					res_fire       = 1'b1;
					res_rsp.status = kts_pkg::ST_WRITE;
				end else if (q_pop && n_now == '0) begin
					res_fire       = 1'b1;
					res_rsp.x      = cfg.empty_value;
					res_rsp.y      = cfg.empty_value;
					res_rsp.z      = cfg.empty_value;
					res_rsp.status = kts_pkg::ST_EMPTY;
				end
			end
			S_SRCH: begin
				if (count_q == '0) begin
					rd_addr = hold_c ? AW'(n_q - CW'(1)) : AW'(idx_c);
				end
			end
			S_HOLD: begin
				res_fire       = 1'b1;
				res_rsp.x      = rd_x;
				res_rsp.y      = rd_y;
				res_rsp.z      = rd_z;
				res_rsp.status = kts_pkg::ST_HOLD;
			end
			S_LD1: begin
				rd_addr = AW'(idx_q + CW'(1));
			end
			S_LD2: begin
				if (rd_time <= t1_q) begin
					res_fire       = 1'b1;
					res_rsp.x      = v1_q[0];
					res_rsp.y      = v1_q[1];
					res_rsp.z      = v1_q[2];
					res_rsp.status = kts_pkg::ST_HOLD;
				end
			end
			S_ADD: begin
				if (comp_q == 2'd2) begin
					res_fire          = 1'b1;
					res_rsp.x         = res_q[0];
					res_rsp.y         = res_q[1];
					res_rsp.z         = rval_c;
					res_rsp.status    = kts_pkg::ST_LERP;
					res_rsp.saturated = sat_q || rsat_c;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (q_pop && !q_cmd.is_write && n_now != '0) state_q <= S_SRCH;
				end
				S_SRCH: begin
					if (count_q != '0) state_q <= S_CMP;
					else if (hold_c) state_q <= S_HOLD;
					else state_q <= S_LD1;
				end
				S_CMP:  state_q <= S_SRCH;
				S_HOLD: state_q <= S_IDLE;
				S_LD1:  state_q <= S_LD2;
				S_LD2:  state_q <= (rd_time <= t1_q) ? S_IDLE : S_DIV;
				S_DIV:  if (cnt_q == DIV_LAST) state_q <= S_FRAC;
				S_FRAC: state_q <= S_MUL;
				S_MUL:  state_q <= S_ADD;
				S_ADD:  state_q <= (comp_q == 2'd2) ? S_IDLE : S_MUL;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				qt_q    <= q_cmd.sample_time;
				n_q     <= n_now;
				first_q <= '0;
				count_q <= n_now;
				sat_q   <= 1'b0;
			end
			S_SRCH: begin
				mid_q <= mid_c;
				idx_q <= idx_c;
			end
			S_CMP: begin
				if (rd_time < qt_q) begin
					first_q <= mid_q + CW'(1);
					count_q <= count_q - (count_q >> 1) - CW'(1);
				end else begin
					count_q <= count_q >> 1;
				end
			end
			S_LD1: begin
				t1_q    <= rd_time;
				v1_q[0] <= rd_x;
				v1_q[1] <= rd_y;
				v1_q[2] <= rd_z;
			end
			S_LD2: begin
				v2_q[0] <= rd_x;
				v2_q[1] <= rd_y;
				v2_q[2] <= rd_z;
				dt_q    <= rd_time - t1_q;
				neg_q   <= (qt_q < t1_q);
				rem_q   <= '0;
				quo_q   <= {mag_c, 16'h0000};
				cnt_q   <= '0;
			end
			S_DIV: begin
				rem_q <= trial[32] ? rem_sh[31:0] : trial[31:0];
				quo_q <= {quo_q[46:0], ~trial[32]};
				cnt_q <= cnt_q + 6'd1;
			end
			S_FRAC: begin
				comp_q <= 2'd0;
				if (neg_q) begin
					if (quo_q > 48'h0000_8000_0000) begin
						frac_q <= 32'sh8000_0000;
						sat_q  <= 1'b1;
					end else begin
						frac_q <= -$signed(quo_q[31:0]);
					end
				end else begin
					if (quo_q > 48'h0000_7FFF_FFFF) begin
						frac_q <= 32'sh7FFF_FFFF;
						sat_q  <= 1'b1;
					end else begin
						frac_q <= $signed(quo_q[31:0]);
					end
				end
			end
			S_MUL: begin
				prod_q <= prod_c;
			end
			S_ADD: begin
				res_q[comp_q] <= rval_c;
				sat_q         <= sat_q || rsat_c;
				comp_q        <= comp_q + 2'd1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_fire) begin
			out_rsp_q <= res_rsp;
		end
	end

	assign out_valid = out_valid_q;
	assign out_rsp   = out_rsp_q;

	`KTS_ASSERT_SAME(a_pop_idle, q_pop, state_q == S_IDLE)
	`KTS_ASSERT_SAME(a_no_overwrite, res_fire, !out_valid_q || out_ready)
	`KTS_ASSERT_SAME(a_mid_in_range, state_q == S_CMP, mid_q < n_q)
	`KTS_ASSERT_NEXT(a_div_len, state_q == S_DIV && cnt_q == DIV_LAST, state_q == S_FRAC)
endmodule
`default_nettype wire

// ===== rtl/core/keyframe_track_lerp_sampler_core.sv =====
// Top level of the keyframe track sampler.
`timescale 1ns / 1ps
`default_nettype none
// Keyframe track sampler, Q16.16. The back end stores a key write in the key
// memory and answers it as it pops the command. A sample is popped, then found by a
// binary search over the key memory (one read and one compare per step, plus a
// final address step); the two bracketing keys are loaded, the one-bit-per-cycle
// restoring divider forms the fraction, the fraction is clipped, and three
// multiply-add steps form the result. Held, empty or degenerate results skip
// the later steps. The front stage and the two-entry queue keep taking beats
// while the back end works, until both are full. The user must write config
// registers only while the block is idle; the block itself does not enforce it.
module keyframe_track_lerp_sampler_core #(
	parameter int MAX_KEYS = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	kts_req_if.sink   req,
	kts_rsp_if.source rsp,
	kts_cfg_if.sink   cfg
);
	kts_pkg::cfg_t cfg_q;
	logic          push_valid, push_ready;
	kts_pkg::cmd_t push_cmd;
	logic          pop_valid, pop;
	kts_pkg::cmd_t pop_cmd;
	logic          out_valid;
	kts_pkg::rsp_t out_rsp;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				kts_pkg::CFG_KEY_COUNT:   cfg_q.key_count   <= cfg.data[6:0];
				kts_pkg::CFG_EMPTY_VALUE: cfg_q.empty_value <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	kts_front #(.MAX_KEYS(MAX_KEYS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	kts_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_cmd    (pop_cmd)
	);

	kts_back #(.MAX_KEYS(MAX_KEYS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (pop_valid),
		.q_pop     (pop),
		.q_cmd     (pop_cmd),
		.out_valid (out_valid),
		.out_ready (rsp.ready),
		.out_rsp   (out_rsp)
	);

	assign rsp.valid     = out_valid;
	assign rsp.out_x     = out_rsp.x;
	assign rsp.out_y     = out_rsp.y;
	assign rsp.out_z     = out_rsp.z;
	assign rsp.status    = out_rsp.status;
	assign rsp.saturated = out_rsp.saturated;
endmodule
`default_nettype wire
